[rtl/core/mlalu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlalu_pkg: shared types and constants of the limb-serial big-integer unit
// Item and result layouts, operation codes and register indexes.
// ----------------------------------------------------------------------------
package mlalu_pkg;

  localparam int unsigned LimbW   = 64;
  localparam int unsigned IdxW    = 6;   // source limb position (64 limbs)
  localparam int unsigned DIdxW   = IdxW + 1;
  localparam int unsigned BitCntW = 13;
  localparam int unsigned ShamtW  = 12;
  localparam int unsigned SOffW   = 6;   // bit offset within a limb
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned QCntW   = 3;

  // Operation carried with each item
  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_SUB    = 3'd1,
    KIND_CMP    = 3'd2,
    KIND_SHL    = 3'd3,
    KIND_SHR    = 3'd4,
    KIND_BITLEN = 3'd5
  } kind_e;

  // Compare verdict codes
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  // Configuration register indexes (paddr[2])
  localparam logic REG_SHIFT_AMOUNT = 1'b0;
  localparam logic REG_EXTEND       = 1'b1;

  typedef struct packed {
    kind_e             kind;
    logic [LimbW-1:0]  a_limb;
    logic [LimbW-1:0]  b_limb;
    logic [IdxW-1:0]   limb_index;
    logic              first_limb;
    logic              last_limb;
  } item_t;

  typedef struct packed {
    logic [LimbW-1:0]   limb_out;
    logic [DIdxW-1:0]   dest_index;
    logic               write_valid;
    logic               carry_flag;
    logic [1:0]         compare_code;
    logic [BitCntW-1:0] bit_count;
    logic [LimbW-1:0]   spill;
    logic               last_out;
  } result_t;

  typedef struct packed {
    logic [ShamtW-1:0] shift_amount;
    logic              extend_result;
  } cfg_t;

endpackage : mlalu_pkg
`default_nettype wire

[rtl/core/multiprecision_limb_alu_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiprecision_limb_alu_core: limb-serial big-integer unit
// Add, subtract, compare, left/right shift and bit length over operands
// streamed one 64-bit limb pair per item.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         tdata {limb_index, b_limb, a_limb}, tuser {first_limb, kind},
//                       tlast last_limb
//  m_axis    out        tdata {spill, bit_count, compare_code, carry_flag,
//                       write_valid, dest_index, limb_out}, tlast last_out
//  apb       in/out     0x0 shift_amount, 0x4 extend_result
//
//  An item passes an input register, then combinational limb logic that writes
//  up to two results into a four-entry queue, whose registers hold them for m_axis.
//  One item per cycle is taken while the queue holds two or fewer results, so
//  an item with two results leaves as two result items on m_axis.
//  Reset clears the chained carry, verdict, shift carry and bit length, and
//  sets extend_result. A stall on m_axis fills the queue, then stops s_axis.
// ----------------------------------------------------------------------------
module multiprecision_limb_alu_core import mlalu_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Limb items in
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [135:0] s_axis_tdata_i,   // a_limb[63:0], b_limb[127:64],
                                              // limb_index[133:128], zero pad
  input  wire logic [3:0]   s_axis_tuser_i,   // kind[2:0], first_limb[3]
  input  wire logic         s_axis_tlast_i,   // last_limb
  // Result items out
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [151:0]      m_axis_tdata_o,   // limb_out[63:0], dest_index[70:64],
                                              // write_valid[71], carry_flag[72],
                                              // compare_code[74:73],
                                              // bit_count[87:75], spill[151:88]
  output logic              m_axis_tlast_o,   // last_out
  // Configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_q;
  logic       s1_valid_q;
  item_t      s1_item_q;
  logic       in_fire;
  logic       s1_adv;
  logic       room;
  logic [1:0] res_cnt;
  result_t    res0, res1, out_res;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXTEND) ?
                  {31'b0, cfg_q.extend_result} : {20'b0, cfg_q.shift_amount};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_amount  <= '0;
      cfg_q.extend_result <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SHIFT_AMOUNT) begin
        cfg_q.shift_amount <= pwdata[ShamtW-1:0];
      end else begin
        cfg_q.extend_result <= pwdata[0];
      end
    end
  end

  // Input register: advance when the queue can take two results
  assign s1_adv          = s1_valid_q & room;
  assign s_axis_tready_o = ~s1_valid_q | s1_adv;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.kind       <= kind_e'(s_axis_tuser_i[2:0]);
      s1_item_q.a_limb     <= s_axis_tdata_i[63:0];
      s1_item_q.b_limb     <= s_axis_tdata_i[127:64];
      s1_item_q.limb_index <= s_axis_tdata_i[133:128];
      s1_item_q.first_limb <= s_axis_tuser_i[3];
      s1_item_q.last_limb  <= s_axis_tlast_i;
    end
  end

  mlalu_exec u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_adv),
    .item_i    (s1_item_q),
    .cfg_i     (cfg_q),
    .res_cnt_o (res_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  mlalu_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (s1_adv ? res_cnt : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .room_o     (room),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .data_o     (out_res)
  );

  // Pack the result item onto the stream
  assign m_axis_tdata_o = {out_res.spill, out_res.bit_count, out_res.compare_code,
                           out_res.carry_flag, out_res.write_valid,
                           out_res.dest_index, out_res.limb_out};
  assign m_axis_tlast_o = out_res.last_out;

endmodule : multiprecision_limb_alu_core
`default_nettype wire

[rtl/core/mlalu_exec.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlalu_exec: limb operation and running state
// Works one registered limb item against the chained carry, verdict, shift
// carry and bit length, and forms up to two result items.
// ----------------------------------------------------------------------------
module mlalu_exec import mlalu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,     // item leaves the input register this cycle
  input  wire item_t   item_i,
  input  wire cfg_t    cfg_i,
  output logic [1:0]   res_cnt_o,
  output result_t      res0_o,
  output result_t      res1_o
);

  logic               carry_q, carry_d, cur_carry;
  logic [1:0]         cmp_q, cmp_d, cur_cmp;
  logic [LimbW-1:0]   sc_q, sc_d, cur_sc;
  logic [BitCntW-1:0] len_q, len_d, cur_len;

  logic [SOffW-1:0]   boff;
  logic [IdxW-1:0]    loff;
  logic [DIdxW-1:0]   inv_s;
  logic [LimbW:0]     sum_w;
  logic [LimbW:0]     dif_w;
  logic [DIdxW-1:0]   shl_idx;
  logic [DIdxW-1:0]   shr_idx;
  logic [LimbW-1:0]   shl_r, shl_c, shr_r, shr_c, shr_sp, shr_idle_sp;
  logic [DIdxW-1:0]   lz;
  logic [BitCntW-1:0] len_w;
  logic [LimbW-1:0]   ar_r;
  logic               ar_c;

  assign boff  = cfg_i.shift_amount[SOffW-1:0];
  assign loff  = cfg_i.shift_amount[ShamtW-1:SOffW];
  assign inv_s = DIdxW'(LimbW) - {1'b0, boff};

  // Clear the running state on the first limb of an operation
  assign cur_carry = item_i.first_limb ? 1'b0 : carry_q;
  assign cur_cmp   = item_i.first_limb ? CMP_EQ : cmp_q;
  assign cur_sc    = item_i.first_limb ? '0 : sc_q;
  assign cur_len   = item_i.first_limb ? '0 : len_q;

  // Add and subtract with the chained carry or borrow
  assign sum_w = {1'b0, item_i.a_limb} + {1'b0, item_i.b_limb} + {{LimbW{1'b0}}, cur_carry};
  assign dif_w = {1'b0, item_i.a_limb} - {1'b0, item_i.b_limb} - {{LimbW{1'b0}}, cur_carry};

  // Shifts; a shift by the full limb width yields zero, covering a zero bit offset
  assign shl_idx     = {1'b0, item_i.limb_index} + {1'b0, loff};
  assign shr_idx     = {1'b0, item_i.limb_index} - {1'b0, loff};
  assign shl_r       = (item_i.a_limb << boff) | cur_sc;
  assign shl_c       = item_i.a_limb >> inv_s;
  assign shr_r       = (item_i.a_limb >> boff) | cur_sc;
  assign shr_c       = item_i.a_limb << inv_s;
  assign shr_sp      = shr_c >> inv_s;
  assign shr_idle_sp = cur_sc >> inv_s;

  // Leading zero count of a (highest set bit wins)
  always_comb begin
    lz = DIdxW'(LimbW);
    for (int i = 0; i < LimbW; i++) begin
      if (item_i.a_limb[i]) begin
        lz = DIdxW'(LimbW - 1 - i);
      end
    end
  end

  assign len_w = ({{(BitCntW-IdxW){1'b0}}, item_i.limb_index} + BitCntW'(1)) << SOffW;

  always_comb begin
    carry_d   = cur_carry;
    cmp_d     = cur_cmp;
    sc_d      = cur_sc;
    len_d     = cur_len;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    ar_r      = '0;
    ar_c      = 1'b0;
    case (item_i.kind)
      KIND_ADD, KIND_SUB: begin
        if (item_i.kind == KIND_ADD) begin
          ar_r = sum_w[LimbW-1:0];
          ar_c = sum_w[LimbW];
        end else begin
          ar_r = dif_w[LimbW-1:0];
          ar_c = dif_w[LimbW];
        end
        carry_d            = ar_c;
        res_cnt_o          = 2'd1;
        res0_o.limb_out    = ar_r;
        res0_o.dest_index  = {1'b0, item_i.limb_index};
        res0_o.write_valid = 1'b1;
        if (item_i.last_limb) begin
          if (cfg_i.extend_result) begin
            res_cnt_o          = 2'd2;
            res1_o.limb_out    = (item_i.kind == KIND_ADD) ?
                                 {{(LimbW-1){1'b0}}, ar_c} : {LimbW{ar_c}};
            res1_o.dest_index  = {1'b0, item_i.limb_index} + DIdxW'(1);
            res1_o.write_valid = 1'b1;
            res1_o.carry_flag  = (item_i.kind == KIND_SUB) & ar_c;
            res1_o.last_out    = 1'b1;
          end else begin
            res0_o.carry_flag = ar_c;
            res0_o.last_out   = 1'b1;
          end
        end
      end
      KIND_CMP: begin
        if (item_i.a_limb < item_i.b_limb) begin
          cmp_d = CMP_LT;
        end else if (item_i.a_limb > item_i.b_limb) begin
          cmp_d = CMP_GT;
        end
        if (item_i.last_limb) begin
          res_cnt_o           = 2'd1;
          res0_o.compare_code = cmp_d;
          res0_o.last_out     = 1'b1;
        end
      end
      KIND_SHL: begin
        sc_d               = shl_c;
        res_cnt_o          = 2'd1;
        res0_o.limb_out    = shl_r;
        res0_o.dest_index  = shl_idx;
        res0_o.write_valid = 1'b1;
        if (item_i.last_limb) begin
          if (cfg_i.extend_result) begin
            res_cnt_o          = 2'd2;
            res1_o.limb_out    = shl_c;
            res1_o.dest_index  = shl_idx + DIdxW'(1);
            res1_o.write_valid = 1'b1;
            res1_o.last_out    = 1'b1;
          end else begin
            res0_o.spill    = shl_c;
            res0_o.last_out = 1'b1;
          end
        end
      end
      KIND_SHR: begin
        if (item_i.limb_index >= loff) begin
          sc_d               = shr_c;
          res_cnt_o          = 2'd1;
          res0_o.limb_out    = shr_r;
          res0_o.dest_index  = shr_idx;
          res0_o.write_valid = 1'b1;
          if (item_i.last_limb) begin
            res0_o.spill    = shr_sp;
            res0_o.last_out = 1'b1;
          end
        end else if (item_i.last_limb) begin
          res_cnt_o       = 2'd1;
          res0_o.spill    = shr_idle_sp;
          res0_o.last_out = 1'b1;
        end
      end
      KIND_BITLEN: begin
        if ((item_i.a_limb != '0) &&
            ((len_w - {{(BitCntW-DIdxW){1'b0}}, lz}) > cur_len)) begin
          len_d = len_w - {{(BitCntW-DIdxW){1'b0}}, lz};
        end
        if (item_i.last_limb) begin
          res_cnt_o        = 2'd1;
          res0_o.bit_count = len_d;
          res0_o.last_out  = 1'b1;
        end
      end
      default: begin
        // Unused kinds: drop the item, keep the state as it was
        carry_d = carry_q;
        cmp_d   = cmp_q;
        sc_d    = sc_q;
        len_d   = len_q;
      end
    endcase
  end

  // Hold the running state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
      cmp_q   <= CMP_EQ;
      sc_q    <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      carry_q <= carry_d;
      cmp_q   <= cmp_d;
      sc_q    <= sc_d;
      len_q   <= len_d;
    end
  end

endmodule : mlalu_exec
`default_nettype wire

[rtl/core/mlalu_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlalu_outq: result queue
// Four-entry register queue that takes up to two result items per cycle
// and hands out one per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module mlalu_outq import mlalu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire result_t push0_i,
  input  wire result_t push1_i,
  output logic       room_o,     // space for two more items
  output logic       valid_o,
  input  wire logic  ready_i,
  output result_t    data_o
);

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ready_i;
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign data_o  = mem_q[rp_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wp_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wp_q + QPtrW'(1)] <= push1_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QPtrW'(push_cnt_i);
      rp_q  <= rp_q + QPtrW'(pop);
      cnt_q <= cnt_q + QCntW'(push_cnt_i) - QCntW'(pop);
    end
  end

endmodule : mlalu_outq
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the limb-serial big-integer unit
// Streams add, subtract, compare, shift and bit-length operations limb by limb
// under random source gaps and sink stalls, predicts every result item in a
// small scoreboard and checks them in order, across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import mlalu_pkg::*;

  // Kinds outside the defined set; the block drops such items
  localparam logic [2:0] KIND_RSVD_LO = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;

  localparam logic [2:0] ADDR_SHIFT  = {REG_SHIFT_AMOUNT, 2'b00};
  localparam logic [2:0] ADDR_EXTEND = {REG_EXTEND, 2'b00};

  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned CFG_EVERY   = 110;
  localparam int unsigned IDLE_GAP    = 12;
  localparam int unsigned TIMEOUT_NS  = 2000000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  idx;
    logic        first;
    logic        last;
  } limb_item_t;

  // Predicts the result items of each accepted limb and checks them in order
  class limb_checker;
    result_t     pending_limbs[$];
    logic [11:0] shamt = '0;
    logic        extend = 1'b1;
    logic        carry;
    logic [1:0]  verdict;
    logic [63:0] shift_carry;
    logic [12:0] bit_len;
    int unsigned errors;
    int unsigned checked;

    function new();
      carry = 1'b0;
      verdict = CMP_EQ;
      shift_carry = '0;
      bit_len = '0;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR %0t ns: %s", $time, msg);
      errors++;
    endtask

    function void push_limb(logic [63:0] limb, logic [6:0] di, logic wv, logic cf,
                            logic [1:0] cc, logic [12:0] bc, logic [63:0] sp,
                            logic lo);
      result_t r;
      r.limb_out = limb;
      r.dest_index = di;
      r.write_valid = wv;
      r.carry_flag = cf;
      r.compare_code = cc;
      r.bit_count = bc;
      r.spill = sp;
      r.last_out = lo;
      pending_limbs.push_back(r);
    endfunction

    function int unsigned lead_zeros(logic [63:0] v);
      int unsigned n;
      n = 0;
      while (n < 64 && v[63-n] == 1'b0) n++;
      return n;
    endfunction

    // Advance the chained state by one item and queue what it produces
    function void predict_limb_results(limb_item_t it);
      logic [64:0] wide;
      logic [63:0] r;
      logic [63:0] sp;
      logic [5:0]  s;
      logic [6:0]  di;
      int unsigned len;
      s = shamt[5:0];
      di = 7'(it.idx) + 7'(shamt[11:6]);
      if (it.kind > KIND_BITLEN) return;
      if (it.first) begin
        carry = 1'b0;
        verdict = CMP_EQ;
        shift_carry = '0;
        bit_len = '0;
      end
      case (it.kind)
        KIND_ADD, KIND_SUB: begin
          if (it.kind == KIND_ADD) wide = {1'b0, it.a} + {1'b0, it.b} + carry;
          else wide = {1'b0, it.a} - {1'b0, it.b} - carry;
          carry = wide[64];
          r = wide[63:0];
          if (!it.last) begin
            push_limb(r, 7'(it.idx), 1'b1, 1'b0, CMP_EQ, '0, '0, 1'b0);
          end else if (extend) begin
            push_limb(r, 7'(it.idx), 1'b1, 1'b0, CMP_EQ, '0, '0, 1'b0);
            if (it.kind == KIND_ADD)
              push_limb({63'd0, carry}, 7'(it.idx) + 7'd1, 1'b1, 1'b0, CMP_EQ, '0,
                        '0, 1'b1);
            else
              push_limb({64{carry}}, 7'(it.idx) + 7'd1, 1'b1, carry, CMP_EQ, '0,
                        '0, 1'b1);
          end else begin
            push_limb(r, 7'(it.idx), 1'b1, carry, CMP_EQ, '0, '0, 1'b1);
          end
        end
        KIND_CMP: begin
          if (it.a < it.b) verdict = CMP_LT;
          else if (it.a > it.b) verdict = CMP_GT;
          if (it.last) push_limb('0, '0, 1'b0, 1'b0, verdict, '0, '0, 1'b1);
        end
        KIND_SHL: begin
          r = (it.a << s) | shift_carry;
          shift_carry = (s != 0) ? (it.a >> (64 - s)) : '0;
          if (!it.last) begin
            push_limb(r, di, 1'b1, 1'b0, CMP_EQ, '0, '0, 1'b0);
          end else if (extend) begin
            push_limb(r, di, 1'b1, 1'b0, CMP_EQ, '0, '0, 1'b0);
            push_limb(shift_carry, di + 7'd1, 1'b1, 1'b0, CMP_EQ, '0, '0, 1'b1);
          end else begin
            push_limb(r, di, 1'b1, 1'b0, CMP_EQ, '0, shift_carry, 1'b1);
          end
        end
        KIND_SHR: begin
          if (it.idx >= shamt[11:6]) begin
            r = (it.a >> s) | shift_carry;
            shift_carry = (s != 0) ? (it.a << (64 - s)) : '0;
            sp = (s != 0) ? (shift_carry >> (64 - s)) : '0;
            di = 7'(it.idx) - 7'(shamt[11:6]);
            if (it.last) push_limb(r, di, 1'b1, 1'b0, CMP_EQ, '0, sp, 1'b1);
            else push_limb(r, di, 1'b1, 1'b0, CMP_EQ, '0, '0, 1'b0);
          end else if (it.last) begin
            // below the limb offset: report the dropped bits only
            sp = (s != 0) ? (shift_carry >> (64 - s)) : '0;
            push_limb('0, '0, 1'b0, 1'b0, CMP_EQ, '0, sp, 1'b1);
          end
        end
        default: begin
          if (it.a != '0) begin
            len = 64 * (int'(it.idx) + 1) - lead_zeros(it.a);
            if (len > bit_len) bit_len = 13'(len);
          end
          if (it.last) push_limb('0, '0, 1'b0, 1'b0, CMP_EQ, bit_len, '0, 1'b1);
        end
      endcase
    endfunction

    task check_limb_result(result_t got);
      result_t want;
      if (pending_limbs.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = pending_limbs.pop_front();
      checked++;
      if (got.limb_out !== want.limb_out)
        report($sformatf("limb_out got %h want %h", got.limb_out, want.limb_out));
      if (got.dest_index !== want.dest_index)
        report($sformatf("dest_index got %0d want %0d", got.dest_index, want.dest_index));
      if (got.write_valid !== want.write_valid)
        report($sformatf("write_valid got %b want %b", got.write_valid, want.write_valid));
      if (got.carry_flag !== want.carry_flag)
        report($sformatf("carry_flag got %b want %b", got.carry_flag, want.carry_flag));
      if (got.compare_code !== want.compare_code)
        report($sformatf("compare_code got %0d want %0d", got.compare_code,
                         want.compare_code));
      if (got.bit_count !== want.bit_count)
        report($sformatf("bit_count got %0d want %0d", got.bit_count, want.bit_count));
      if (got.spill !== want.spill)
        report($sformatf("spill got %h want %h", got.spill, want.spill));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out got %b want %b", got.last_out, want.last_out));
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;   // a_limb, b_limb, limb_index, zero pad
  logic [3:0]   s_tuser;   // kind, first_limb
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [151:0] m_tdata;   // limb_out, dest_index, write_valid, carry_flag,
                           // compare_code, bit_count, spill
  logic         m_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  limb_checker tracker = new();
  int unsigned burst_left = 0;
  int unsigned n_items = 0;
  int unsigned n_ops = 0;
  int unsigned n_cfg = 0;

  multiprecision_limb_alu_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Sink: stall patterns that change over time, plus a long hold-off now and then
  initial begin
    int unsigned pattern;
    int unsigned pattern_left;
    int unsigned hold_left;
    int unsigned cyc;
    m_tready = 1'b0;
    pattern = 0;
    pattern_left = 0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 1500 == 400) hold_left = 80;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = $urandom_range(0, 2);
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (pattern)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check each result item taken by the sink
  always @(posedge clk) begin
    result_t got;
    if (rst_n && m_tvalid && m_tready) begin
      got.limb_out = m_tdata[63:0];
      got.dest_index = m_tdata[70:64];
      got.write_valid = m_tdata[71];
      got.carry_flag = m_tdata[72];
      got.compare_code = m_tdata[74:73];
      got.bit_count = m_tdata[87:75];
      got.spill = m_tdata[151:88];
      got.last_out = m_tlast;
      tracker.check_limb_result(got);
    end
  end

  // Offer one item, with a random gap before each new burst; ends at a falling edge
  task automatic send_item(input limb_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, it.idx, it.b, it.a};
    s_tuser <= {it.first, it.kind};
    s_tlast <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.predict_limb_results(it);
    if (it.kind <= KIND_BITLEN) n_items++;
    @(negedge clk);
  endtask

  task automatic send_limb(input logic [2:0] kind, input logic [63:0] a,
                           input logic [63:0] b, input logic [5:0] idx,
                           input logic first, input logic last);
    limb_item_t it;
    it.kind = kind;
    it.a = a;
    it.b = b;
    it.idx = idx;
    it.first = first;
    it.last = last;
    send_item(it);
  endtask

  // Hold off the source until every expected item is back and the pipe is empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tracker.pending_limbs.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write both registers, read them back and update the prediction
  task automatic set_regs(input logic [11:0] shamt, input logic ext);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_SHIFT, {20'd0, shamt}, rd);
    tracker.shamt = shamt;
    apb_access(1'b0, ADDR_SHIFT, '0, rd);
    if (rd !== {20'd0, shamt})
      tracker.report($sformatf("shift_amount reads %h want %h", rd, shamt));
    apb_access(1'b1, ADDR_EXTEND, {31'd0, ext}, rd);
    tracker.extend = ext;
    apb_access(1'b0, ADDR_EXTEND, '0, rd);
    if (rd !== {31'd0, ext})
      tracker.report($sformatf("extend_result reads %h want %h", rd, ext));
    n_cfg++;
  endtask

  function automatic logic [63:0] rand_limb();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One operation with random content; sometimes without its first or last mark
  task automatic send_op(input logic [2:0] kind);
    int unsigned n;
    int unsigned top;
    int unsigned base;
    int unsigned k;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  idx;
    bit          drop_first;
    bit          drop_last;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 64) : $urandom_range(1, 6);
    drop_first = ($urandom_range(0, 15) == 0);
    drop_last = ($urandom_range(0, 15) == 0);
    top = int'(tracker.shamt[11:6]) + $urandom_range(0, 3);
    if (top > 63) top = 63;
    base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64 - n) : 0;
    if (kind == KIND_SHR && n > top + 1) n = top + 1;
    for (k = 0; k < n; k++) begin
      idx = (kind == KIND_SHR) ? 6'(top - k) : 6'(base + k);
      a = rand_limb();
      if (kind == KIND_CMP && $urandom_range(0, 3) != 0) b = a;
      else if ((kind == KIND_ADD || kind == KIND_SUB) && $urandom_range(0, 3) == 0)
        b = ~a;
      else b = rand_limb();
      send_limb(kind, a, b, idx, (k == 0) && !drop_first, (k == n - 1) && !drop_last);
    end
    n_ops++;
  endtask

  // Stimulus
  initial begin
    int unsigned phase;
    int unsigned next_cfg;
    logic [11:0] shamt;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: carry and borrow chains into the extra limb
    send_limb(KIND_ADD, '1, 64'd1, 6'd0, 1'b1, 1'b0);
    send_limb(KIND_ADD, '1, '0, 6'd1, 1'b0, 1'b1);
    send_limb(KIND_SUB, '0, 64'd1, 6'd0, 1'b1, 1'b0);
    send_limb(KIND_SUB, '0, '0, 6'd1, 1'b0, 1'b1);
    // higher limbs override the verdict of lower ones
    send_limb(KIND_CMP, 64'd5, 64'd3, 6'd0, 1'b1, 1'b0);
    send_limb(KIND_CMP, 64'd1, 64'd2, 6'd1, 1'b0, 1'b0);
    send_limb(KIND_CMP, 64'd7, 64'd7, 6'd2, 1'b0, 1'b1);
    send_limb(KIND_CMP, '1, '1, 6'd0, 1'b1, 1'b1);
    // shifts by zero bits
    send_limb(KIND_SHL, '1, '0, 6'd0, 1'b1, 1'b0);
    send_limb(KIND_SHL, 64'd1, '0, 6'd1, 1'b0, 1'b1);
    send_limb(KIND_SHR, '1, '0, 6'd1, 1'b1, 1'b0);
    send_limb(KIND_SHR, 64'd1, '0, 6'd0, 1'b0, 1'b1);
    // bit length out of order, then a zero operand
    send_limb(KIND_BITLEN, 64'd1, '0, 6'd3, 1'b1, 1'b0);
    send_limb(KIND_BITLEN, '1, '0, 6'd1, 1'b0, 1'b0);
    send_limb(KIND_BITLEN, '0, '0, 6'd0, 1'b0, 1'b1);
    send_limb(KIND_BITLEN, '0, '0, 6'd0, 1'b1, 1'b1);
    // undefined kinds in the middle of an add leave the carry alone
    send_limb(KIND_ADD, '1, '1, 6'd0, 1'b1, 1'b0);
    send_limb(KIND_RSVD_LO, '1, '1, 6'd5, 1'b1, 1'b1);
    send_limb(KIND_RSVD_HI, '1, '1, 6'd63, 1'b1, 1'b0);
    send_limb(KIND_ADD, '0, '0, 6'd1, 1'b0, 1'b1);
    // kind change without a first limb keeps the running carry
    send_limb(KIND_ADD, '1, 64'd1, 6'd0, 1'b1, 1'b0);
    send_limb(KIND_SUB, '0, '0, 6'd1, 1'b0, 1'b1);
    send_limb(KIND_ADD, '1, '1, 6'd63, 1'b1, 1'b1);
    // largest shift with no extra limb: spill reported
    wait_idle();
    set_regs(12'd4095, 1'b0);
    send_limb(KIND_SHL, '1, '0, 6'd63, 1'b1, 1'b1);
    send_limb(KIND_SHR, '1, '0, 6'd63, 1'b1, 1'b0);
    send_limb(KIND_SHR, '1, '0, 6'd62, 1'b0, 1'b1);

    // Random operations, with a new register setting every so often
    phase = 0;
    next_cfg = n_items;
    while (n_items < ITEM_TARGET) begin
      if (n_items >= next_cfg) begin
        wait_idle();
        case (phase % 8)
          0: shamt = 12'd0;
          1: shamt = 12'd4095;
          2: shamt = 12'd1;
          3: shamt = 12'd63;
          4: shamt = 12'd64;
          default: shamt = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
                                                        : 12'($urandom_range(0, 200));
        endcase
        set_regs(shamt, phase[0]);
        phase++;
        next_cfg = n_items + CFG_EVERY;
      end
      if ($urandom_range(0, 9) == 0)
        send_limb(3'($urandom_range(0, 7)), {$urandom, $urandom}, {$urandom, $urandom},
                  6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        send_op(3'($urandom_range(0, 5)));
    end

    // Drain and report
    wait_idle();
    $display("Covered %0d limb items in %0d random operations over %0d register settings,",
             n_items, n_ops, n_cfg);
    $display("with %0d result items checked and %0d mismatches.",
             tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS multiprecision_limb_alu_core");
    end else begin
      $display("FAIL multiprecision_limb_alu_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d result items still expected",
             tracker.pending_limbs.size());
    $display("FAIL multiprecision_limb_alu_core");
    $finish;
  end

endmodule
